/* rtl/core/lia_pkg.sv */
// Shared types and constants for the line assembler.
`default_nettype none
package lia_pkg;

  // Input item kinds carried on in_tuser
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Flush causes
  localparam logic [1:0] CAUSE_END  = 2'd0;
  localparam logic [1:0] CAUSE_FULL = 2'd1;
  localparam logic [1:0] CAUSE_IDLE = 2'd2;

  // Byte codes
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] PRINT_LO      = 8'h20;
  localparam logic [7:0] PRINT_END     = 8'h7F;

  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned LINE_NUM_W = 32;
  localparam int unsigned CAUSE_W    = 2;

  localparam logic [TICK_W-1:0] IDLE_LIMIT_RST = 16'd400;
  localparam logic [TICK_W-1:0] TICK_SAT       = 16'hFFFF;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_FLUSH
  } lia_state_t;

  // Per-character attributes that travel with a store read
  typedef struct packed {
    logic                  last;
    logic [LINE_NUM_W-1:0] num;
    logic [CAUSE_W-1:0]    cause;
  } lia_meta_t;

  // Read request from the controller to the output queue
  typedef struct packed {
    logic      issue;
    lia_meta_t meta;
  } lia_rdreq_t;

endpackage
`default_nettype wire

/* rtl/core/line_assembler_idle_flush.sv */
// Top level of the line assembler with idle-timeout flush.
// Assembles printable bytes (0x20..0x7E) from a byte/tick stream into lines held in a
// MAX_LINE-entry line store and replays each finished line as one transfer per character.
// A line ends on CR or LF (if non-empty), when the store is full and another printable
// byte arrives, or when cfg idle limit ticks have passed since the last byte. Each
// character carries the line number (lines flushed so far, first line is 1) and the cause.
// Flow: a byte or tick that ends no line does not stall the input. An item that flushes a
// line holds the input while the line is read out, and while the held byte is written if
// the store was full: the store has one read port, read one character per cycle while the
// output queue has room (backpressure). Write cfg only while no transfer is pending.
`default_nettype none
module line_assembler_idle_flush #(
  parameter int MAX_LINE = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] mode (0 = byte, 1 = tick)
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [6:0] line_char, [38:7] line_number, [39] zero
  output logic             out_tlast,  // last_of_line
  output logic      [1:0]  out_tuser,  // [1:0] flush_cause
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata   // idle_limit_ticks
);

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int LW = $clog2(MAX_LINE + 1);

  lia_pkg::lia_rdreq_t            rdreq;
  lia_pkg::lia_meta_t             out_meta;
  logic                           space;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [lia_pkg::CHAR_W-1:0]     mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [lia_pkg::CHAR_W-1:0]     mem_rdata;
  logic [lia_pkg::CHAR_W-1:0]     out_char;

  lia_ctrl #(
    .MAX_LINE (MAX_LINE),
    .AW       (AW),
    .LW       (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_byte   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .space     (space),
    .rdreq     (rdreq),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr)
  );

  // line store
  lia_ram #(
    .WIDTH (lia_pkg::CHAR_W),
    .DEPTH (MAX_LINE),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lia_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .rdreq     (rdreq),
    .rdata     (mem_rdata),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_meta  (out_meta)
  );

  assign out_tdata = {1'b0, out_meta.num, out_char};
  assign out_tlast = out_meta.last;
  assign out_tuser = out_meta.cause;

endmodule
`default_nettype wire

/* rtl/core/lia_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module lia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lia_outq.sv */
// Output queue: read-pending stage, hold slot and output register.
`default_nettype none
module lia_outq (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lia_pkg::lia_rdreq_t                   rdreq,
  input  wire logic [lia_pkg::CHAR_W-1:0]            rdata,
  output logic                                       space,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic      [lia_pkg::CHAR_W-1:0]            out_char,
  output lia_pkg::lia_meta_t                         out_meta
);

  logic                         pend_v_r, pend_v_nxt;
  lia_pkg::lia_meta_t           pend_meta_r, pend_meta_nxt;
  logic                         hold_v_r, hold_v_nxt;
  logic [lia_pkg::CHAR_W-1:0]   hold_char_r, hold_char_nxt;
  lia_pkg::lia_meta_t           hold_meta_r, hold_meta_nxt;
  logic                         out_v_r, out_v_nxt;
  logic [lia_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  lia_pkg::lia_meta_t           out_meta_r, out_meta_nxt;

  logic       out_take;
  logic       out_free;
  logic [1:0] occ;

  assign out_take = out_v_r && out_ready;
  assign out_free = !out_v_r || out_take;
  assign occ      = 2'(out_v_r) + 2'(hold_v_r) + 2'(pend_v_r);
  // at most two characters in flight past the store
  assign space    = (occ < 2'd2) || ((occ == 2'd2) && out_take);

  // queue movement, oldest first: out, hold, pending read
  always_comb begin
    pend_v_nxt    = rdreq.issue;
    pend_meta_nxt = rdreq.meta;
    hold_v_nxt    = hold_v_r;
    hold_char_nxt = hold_char_r;
    hold_meta_nxt = hold_meta_r;
    out_v_nxt     = out_v_r;
    out_char_nxt  = out_char_r;
    out_meta_nxt  = out_meta_r;
    if (out_free) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_char_nxt = hold_char_r;
        out_meta_nxt = hold_meta_r;
        hold_v_nxt   = pend_v_r;
        hold_char_nxt = rdata;
        hold_meta_nxt = pend_meta_r;
      end else if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_char_nxt = rdata;
        out_meta_nxt = pend_meta_r;
      end else begin
        out_v_nxt    = 1'b0;
      end
    end else if (pend_v_r) begin
      hold_v_nxt    = 1'b1;
      hold_char_nxt = rdata;
      hold_meta_nxt = pend_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_meta_r <= pend_meta_nxt;
    hold_char_r <= hold_char_nxt;
    hold_meta_r <= hold_meta_nxt;
    out_char_r  <= out_char_nxt;
    out_meta_r  <= out_meta_nxt;
  end

  assign out_valid = out_v_r;
  assign out_char  = out_char_r;
  assign out_meta  = out_meta_r;

endmodule
`default_nettype wire

/* rtl/core/lia_ctrl.sv */
// Controller: input decode, line length, idle counter and flush sequencer.
`default_nettype none
module lia_ctrl #(
  parameter int MAX_LINE = 32,
  parameter int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1,
  parameter int LW = $clog2(MAX_LINE + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_mode,
  input  wire logic [7:0]                       in_byte,
  input  wire logic                             cfg_we,
  input  wire logic [lia_pkg::TICK_W-1:0]       cfg_wdata,
  input  wire logic                             space,
  output lia_pkg::lia_rdreq_t                   rdreq,
  output logic                                  mem_we,
  output logic      [AW-1:0]                    mem_waddr,
  output logic      [lia_pkg::CHAR_W-1:0]       mem_wdata,
  output logic                                  mem_re,
  output logic      [AW-1:0]                    mem_raddr
);

  localparam logic [LW-1:0] LEN_FULL = LW'(MAX_LINE);

  lia_pkg::lia_state_t state_r, state_nxt;

  logic [LW-1:0]                      len_r, len_nxt;
  logic [LW-1:0]                      idx_r, idx_nxt;
  logic [lia_pkg::TICK_W-1:0]         ticks_r, ticks_nxt;
  logic [lia_pkg::TICK_W-1:0]         limit_r, limit_nxt;
  logic [lia_pkg::LINE_NUM_W-1:0]     lines_r, lines_nxt;
  logic [lia_pkg::CAUSE_W-1:0]        cause_r, cause_nxt;
  logic                               app_r, app_nxt;
  logic [lia_pkg::CHAR_W-1:0]         app_char_r, app_char_nxt;

  logic                               accept;
  logic                               start_flush;
  logic                               last_issue;
  logic                               is_eol;
  logic                               is_print;
  logic [lia_pkg::TICK_W-1:0]         ticks_inc;

  assign in_ready  = (state_r == lia_pkg::ST_IDLE) && !app_r;
  assign accept    = in_valid && in_ready;
  assign is_eol    = (in_byte == lia_pkg::BYTE_LF) || (in_byte == lia_pkg::BYTE_CR);
  assign is_print  = (in_byte >= lia_pkg::PRINT_LO) && (in_byte < lia_pkg::PRINT_END);
  assign ticks_inc = (ticks_r == lia_pkg::TICK_SAT) ? ticks_r
                                                    : ticks_r + lia_pkg::TICK_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lia_pkg::ST_IDLE: begin
        if (start_flush) state_nxt = lia_pkg::ST_FLUSH;
      end
      lia_pkg::ST_FLUSH: begin
        if (last_issue) state_nxt = lia_pkg::ST_IDLE;
      end
      default: state_nxt = lia_pkg::ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    ticks_nxt    = ticks_r;
    limit_nxt    = cfg_we ? cfg_wdata : limit_r;
    lines_nxt    = lines_r;
    cause_nxt    = cause_r;
    app_nxt      = app_r;
    app_char_nxt = app_char_r;
    start_flush  = 1'b0;
    last_issue   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = len_r[AW-1:0];
    mem_wdata    = in_byte[lia_pkg::CHAR_W-1:0];
    mem_re       = 1'b0;
    mem_raddr    = idx_r[AW-1:0];
    rdreq.issue      = 1'b0;
    rdreq.meta.last  = (idx_r == len_r - LW'(1));
    rdreq.meta.num   = lines_r;
    rdreq.meta.cause = cause_r;

    unique case (state_r)
      lia_pkg::ST_IDLE: begin
        if (app_r) begin
          // byte held over from a full-store flush starts the new line
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = app_char_r;
          len_nxt   = LW'(1);
          app_nxt   = 1'b0;
        end else if (accept) begin
          if (in_mode == lia_pkg::MODE_TICK) begin
            ticks_nxt = ticks_inc;
            if ((len_r != '0) && (ticks_inc >= limit_r)) begin
              start_flush = 1'b1;
              cause_nxt   = lia_pkg::CAUSE_IDLE;
            end
          end else begin
            ticks_nxt = '0;
            if (is_eol) begin
              if (len_r != '0) begin
                start_flush = 1'b1;
                cause_nxt   = lia_pkg::CAUSE_END;
              end
            end else if (is_print) begin
              if (len_r == LEN_FULL) begin
                start_flush  = 1'b1;
                cause_nxt    = lia_pkg::CAUSE_FULL;
                app_nxt      = 1'b1;
                app_char_nxt = in_byte[lia_pkg::CHAR_W-1:0];
              end else begin
                mem_we  = 1'b1;
                len_nxt = len_r + LW'(1);
              end
            end
          end
          if (start_flush) begin
            idx_nxt   = '0;
            lines_nxt = lines_r + lia_pkg::LINE_NUM_W'(1);
          end
        end
      end
      lia_pkg::ST_FLUSH: begin
        // one store read per cycle while the output queue has room
        if (space) begin
          mem_re      = 1'b1;
          rdreq.issue = 1'b1;
          idx_nxt     = idx_r + LW'(1);
          if (rdreq.meta.last) begin
            last_issue = 1'b1;
            len_nxt    = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lia_pkg::ST_IDLE;
      len_r   <= '0;
      ticks_r <= '0;
      limit_r <= lia_pkg::IDLE_LIMIT_RST;
      lines_r <= '0;
      app_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ticks_r <= ticks_nxt;
      limit_r <= limit_nxt;
      lines_r <= lines_nxt;
      app_r   <= app_nxt;
    end
    idx_r      <= idx_nxt;
    cause_r    <= cause_nxt;
    app_char_r <= app_char_nxt;
  end

endmodule
`default_nettype wire
